@@ rtl/cefq_pkg.sv @@
// Shared types, constants and a helper function of the cartoon edge and quantise filter.
package cefq_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int PIX_W      = 8;
  localparam int NUM_CH     = 3;
  localparam int WIN        = 5;
  localparam int NUM_LINES  = 4;
  localparam int PX_W       = NUM_CH * PIX_W;
  localparam int WORD_W     = NUM_LINES * PX_W;
  localparam int ADDR_W     = $clog2(MAX_WIDTH);
  localparam int CNT_W      = 11;
  localparam int MAG_W      = 9;
  localparam int SUM_W      = 12;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH     = 2'd0;
  localparam logic [1:0] REG_HEIGHT    = 2'd1;
  localparam logic [1:0] REG_LEVELS    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  // One channel's 5x5 window: [row, 0 top][column, 0 oldest].
  typedef logic [WIN-1:0][WIN-1:0][PIX_W-1:0] chan_win_t;

  // What one lane hands to the merging stage.
  typedef struct packed {
    logic [PIX_W-1:0] quant;
    logic [MAG_W-1:0] mag;
  } lane_res_t;

  // Division by ten through a reciprocal; exact for values below 2560.
  function automatic logic [PIX_W-1:0] div10(input logic [SUM_W-1:0] x);
    logic [SUM_W+13-1:0] p;
    begin
      p = {13'd0, x} * (SUM_W + 13)'(6554);
      return p[16 +: PIX_W];
    end
  endfunction

endpackage

@@ rtl/cefq_line_store.sv @@
// Line store: four rows of pixels side by side in one word per column.
module cefq_line_store (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [cefq_pkg::ADDR_W-1:0] rd_addr,
  output logic [cefq_pkg::WORD_W-1:0] rd_data,
  input  logic                        wr_en,
  input  logic [cefq_pkg::ADDR_W-1:0] wr_addr,
  input  logic [cefq_pkg::WORD_W-1:0] wr_data
);
  import cefq_pkg::*;

  logic [WORD_W-1:0] mem [MAX_WIDTH];

  // Single write port and registered read port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

@@ rtl/cefq_lane.sv @@
// One channel lane: blur, quantisation and Sobel magnitude, worked out step by step.
module cefq_lane (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  cefq_pkg::chan_win_t        win,
  input  logic [cefq_pkg::PIX_W-1:0] bucket,
  output cefq_pkg::lane_res_t        res,
  output logic                       done
);
  import cefq_pkg::*;

  logic                 busy;
  logic [3:0]           step;
  logic [PIX_W-1:0]     hor [WIN];
  logic [PIX_W-1:0]     gx_abs;
  logic [PIX_W-1:0]     gy_abs;
  logic [PIX_W-1:0]     blur;
  logic [16:0]          sq;
  logic [PIX_W:0]       rem;
  logic [PIX_W-1:0]     dvd;
  logic [MAG_W-1:0]     root;

  logic [SUM_W-1:0]     hsum [WIN];
  logic [SUM_W-1:0]     vsum;
  logic signed [11:0]   sx;
  logic [SUM_W-1:0]     hs1;
  logic [SUM_W-1:0]     hs3;
  logic signed [9:0]    gy;
  logic [3:0]           it;
  logic [MAG_W-1:0]     trial;
  logic [17:0]          trial_sq;
  logic [PIX_W:0]       dtrial;

  // Row sums of the blur and the Sobel terms.
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      hsum[r] = SUM_W'(win[r][0]) + (SUM_W'(win[r][1]) << 1) + (SUM_W'(win[r][2]) << 2)
              + (SUM_W'(win[r][3]) << 1) + SUM_W'(win[r][4]);
    end
    vsum = SUM_W'(hor[0]) + (SUM_W'(hor[1]) << 1) + (SUM_W'(hor[2]) << 2)
         + (SUM_W'(hor[3]) << 1) + SUM_W'(hor[4]);
    sx = (12'(signed'({1'b0, win[1][3]})) - 12'(signed'({1'b0, win[1][1]})))
       + ((12'(signed'({1'b0, win[2][3]})) - 12'(signed'({1'b0, win[2][1]}))) <<< 1)
       + (12'(signed'({1'b0, win[3][3]})) - 12'(signed'({1'b0, win[3][1]})));
    hs1 = (SUM_W'(win[1][1]) + (SUM_W'(win[1][2]) << 1) + SUM_W'(win[1][3])) >> 2;
    hs3 = (SUM_W'(win[3][1]) + (SUM_W'(win[3][2]) << 1) + SUM_W'(win[3][3])) >> 2;
    gy  = signed'({2'b00, hs1[PIX_W-1:0]}) - signed'({2'b00, hs3[PIX_W-1:0]});
  end

  // Iteration step: one quotient bit and one root bit per cycle.
  always_comb begin
    it       = step - 4'd2;
    trial    = root | (MAG_W'(9'd256) >> it);
    trial_sq = trial * trial;
    dtrial   = {rem[PIX_W-1:0], dvd[PIX_W-1]};
  end

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= step + 4'd1;
        if (step == 4'd10) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      for (int r = 0; r < WIN; r++) begin
        hor[r] <= div10(hsum[r]);
      end
      if (sx < 0) begin
        gx_abs <= PIX_W'((-sx) >>> 2);
      end else begin
        gx_abs <= PIX_W'(sx >>> 2);
      end
      gy_abs <= (gy < 0) ? PIX_W'(-gy) : PIX_W'(gy);
    end else if (busy) begin
      if (step == 4'd0) begin
        blur <= div10(vsum);
        sq   <= 17'(gx_abs * gx_abs) + 17'(gy_abs * gy_abs);
      end else if (step == 4'd1) begin
        rem  <= '0;
        dvd  <= blur;
        root <= '0;
      end else begin
        if (trial_sq <= {1'b0, sq}) begin
          root <= trial;
        end
        if (it < 4'd8) begin
          dvd <= dvd << 1;
          if (dtrial >= {1'b0, bucket}) begin
            rem <= dtrial - {1'b0, bucket};
          end else begin
            rem <= dtrial;
          end
        end
      end
    end
  end

  assign res.quant = blur - rem[PIX_W-1:0];
  assign res.mag   = root;

endmodule

@@ rtl/cefq_merge.sv @@
// Merging stage: edge decision over all lanes and the output register.
module cefq_merge (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       load,
  input  cefq_pkg::lane_res_t        res [cefq_pkg::NUM_CH],
  input  logic [cefq_pkg::MAG_W-1:0] thr,
  input  logic                       row_end,
  input  logic                       frame_end,
  output logic                       free,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cefq_pkg::PX_W-1:0]  m_tdata,
  output logic                       m_tlast,
  output logic                       m_tuser
);
  import cefq_pkg::*;

  logic black;

  // A pixel turns black when any channel has a strong edge.
  always_comb begin
    black = 1'b0;
    for (int ch = 0; ch < NUM_CH; ch++) begin
      if (res[ch].mag > thr) begin
        black = 1'b1;
      end
    end
  end

  assign free = !m_tvalid || m_tready;

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        m_tdata[ch*PIX_W +: PIX_W] <= black ? '0 : res[ch].quant;
      end
      m_tlast <= row_end;
      m_tuser <= frame_end;
    end
  end

endmodule

@@ rtl/cartoon_edge_quantize_filter_unit.sv @@
// Top level of the cartoon filter: window, counters, sequencing and lanes.
//
// Pixels enter on the s_ stream in raster order, one request per pixel, tdata
// holding blue, green and red from the lowest byte up. Once four rows and four
// columns have been seen, each request yields the cartoon pixel at the window
// centre on the m_ stream; border pixels produce no result. m_tlast marks the
// last pixel of an output row and m_tuser the last pixel of the frame.
// A request that yields a result goes through the lanes to the output
// register; the pace is set by the bit-per-cycle divider and square root in
// the three channel lanes, which run side by side. The next request is taken
// once the previous one has left the lanes, while its result still waits in
// the output register. If the receiver stalls, a finished result holds in the
// output register and one further request is processed; the block then waits
// until the register frees. The user is to write registers on the cfg_ channel
// only while the block is idle; the block itself does not enforce it. A write
// to levels recomputes the bucket size, and no pixel is taken meanwhile. Reset
// restores the register defaults, clears the window and the counters; the line
// store holds no reset value and needs no clearing.
module cartoon_edge_quantize_filter_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [cefq_pkg::PX_W-1:0]  s_tdata,  // blue_in, green_in, red_in
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [cefq_pkg::PX_W-1:0]  m_tdata,  // blue_out, green_out, red_out
  output logic                       m_tlast,
  output logic                       m_tuser,  // frame_end
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [1:0]                 cfg_index,
  input  logic [cefq_pkg::CNT_W-1:0] cfg_data
);
  import cefq_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SHIFT = 3'd1;
  localparam logic [2:0] ST_START = 3'd2;
  localparam logic [2:0] ST_RUN   = 3'd3;
  localparam logic [2:0] ST_OUT   = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  frame_width;
  logic [CNT_W-1:0]  frame_height;
  logic [PIX_W-1:0]  levels;
  logic [MAG_W-1:0]  mag_threshold;
  logic [PIX_W-1:0]  bucket;
  logic              bkt_busy;
  logic [3:0]        bkt_step;
  logic [PIX_W:0]    bkt_rem;
  logic [PIX_W-1:0]  bkt_dvd;
  logic [CNT_W-1:0]  column_count;
  logic [CNT_W-1:0]  row_count;
  logic [CNT_W-1:0]  col;
  logic [CNT_W-1:0]  row;
  logic [PX_W-1:0]   px;
  logic              emit;
  logic              row_end;
  logic              frame_end;
  chan_win_t         win [NUM_CH];

  logic [CNT_W-1:0]  w_eff;
  logic [CNT_W-1:0]  h_eff;
  logic [CNT_W-1:0]  col_next;
  logic [CNT_W-1:0]  row_next;
  logic [CNT_W-1:0]  row_inc;
  logic              accept;
  logic [WORD_W-1:0] rd_word;
  logic [WORD_W-1:0] wr_word;
  logic [PIX_W-1:0]  bkt_div;
  logic [PIX_W:0]    bkt_trial;
  lane_res_t         res [NUM_CH];
  logic [NUM_CH-1:0] lane_done;
  logic              merge_free;
  logic              merge_load;

  assign cfg_ready  = 1'b1;
  assign s_tready   = (state == ST_IDLE) && !bkt_busy;
  assign accept     = s_tvalid && s_tready;
  assign merge_load = (state == ST_OUT) && merge_free;

  // Effective frame size and the position of the incoming pixel.
  always_comb begin
    if (frame_width < CNT_W'(5)) begin
      w_eff = CNT_W'(5);
    end else if (frame_width > CNT_W'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < CNT_W'(5)) begin
      h_eff = CNT_W'(5);
    end else if (frame_height > CNT_W'(MAX_HEIGHT)) begin
      h_eff = CNT_W'(MAX_HEIGHT);
    end else begin
      h_eff = frame_height;
    end
    if (column_count >= w_eff) begin
      col_next = '0;
      row_inc  = row_count + CNT_W'(1);
    end else begin
      col_next = column_count;
      row_inc  = row_count;
    end
    row_next = (row_inc >= h_eff) ? '0 : row_inc;
  end

  // New line store word: the oldest row in this slot takes the new pixel.
  always_comb begin
    wr_word = rd_word;
    wr_word[row[1:0]*PX_W +: PX_W] = px;
  end

  // Bucket size: 255 divided by levels (zero taken as one), one quotient bit a cycle while no cfg_ write comes in.
  assign bkt_div   = (levels == '0) ? PIX_W'(1) : levels;
  assign bkt_trial = {bkt_rem[PIX_W-1:0], 1'b1};

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= CNT_W'(640);
      frame_height  <= CNT_W'(480);
      levels        <= PIX_W'(10);
      mag_threshold <= MAG_W'(15);
      bucket        <= PIX_W'(25);
      bkt_busy      <= 1'b0;
      bkt_step      <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_WIDTH:     frame_width   <= cfg_data;
          REG_HEIGHT:    frame_height  <= cfg_data;
          REG_LEVELS: begin
            levels   <= cfg_data[PIX_W-1:0];
            bkt_busy <= 1'b1;
            bkt_step <= '0;
          end
          REG_THRESHOLD: mag_threshold <= cfg_data[MAG_W-1:0];
          default: ;
        endcase
      end else if (bkt_busy) begin
        bkt_step <= bkt_step + 4'd1;
        if (bkt_step == 4'd9) begin
          bkt_busy <= 1'b0;
          bucket   <= bkt_dvd;
        end
      end
    end
  end

  // Divider datapath; the dividend is all ones, so each step shifts in a one.
  always_ff @(posedge clk) begin
    if (bkt_busy && !cfg_valid) begin
      if (bkt_step == 4'd0) begin
        bkt_rem <= '0;
        bkt_dvd <= '0;
      end else if (bkt_trial >= {1'b0, bkt_div}) begin
        bkt_rem <= bkt_trial - {1'b0, bkt_div};
        bkt_dvd <= {bkt_dvd[PIX_W-2:0], 1'b1};
      end else begin
        bkt_rem <= bkt_trial;
        bkt_dvd <= {bkt_dvd[PIX_W-2:0], 1'b0};
      end
    end
  end

  // Request sequencer and position counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      column_count <= '0;
      row_count    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            column_count <= col_next + CNT_W'(1);
            row_count    <= row_next;
            state        <= ST_SHIFT;
          end
        end
        ST_SHIFT: state <= emit ? ST_START : ST_IDLE;
        ST_START: state <= ST_RUN;
        ST_RUN:   state <= (&lane_done) ? ST_OUT : ST_RUN;
        ST_OUT:   state <= merge_free ? ST_IDLE : ST_OUT;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // Latched request and its position flags.
  always_ff @(posedge clk) begin
    if (accept) begin
      px        <= s_tdata;
      col       <= col_next;
      row       <= row_next;
      emit      <= (row_next >= CNT_W'(4)) && (col_next >= CNT_W'(4));
      row_end   <= col_next == w_eff - CNT_W'(1);
      frame_end <= (col_next == w_eff - CNT_W'(1)) && (row_next == h_eff - CNT_W'(1));
    end
  end

  // Window: shift left and take the new column from the line store and the request.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        win[ch] <= '0;
      end
    end else if (state == ST_SHIFT) begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
        for (int r = 0; r < WIN; r++) begin
          for (int c = 0; c < WIN - 1; c++) begin
            win[ch][r][c] <= win[ch][r][c+1];
          end
        end
        for (int r = 0; r < NUM_LINES; r++) begin
          win[ch][r][WIN-1] <= rd_word[(2'(row[1:0] + 2'(r)))*PX_W + ch*PIX_W +: PIX_W];
        end
        win[ch][WIN-1][WIN-1] <= px[ch*PIX_W +: PIX_W];
      end
    end
  end

  cefq_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_next[ADDR_W-1:0]),
    .rd_data (rd_word),
    .wr_en   (state == ST_SHIFT),
    .wr_addr (col[ADDR_W-1:0]),
    .wr_data (wr_word)
  );

  // One lane per colour channel.
  for (genvar ch = 0; ch < NUM_CH; ch++) begin : g_lane
    cefq_lane u_lane (
      .clk    (clk),
      .rst    (rst),
      .start  (state == ST_START),
      .win    (win[ch]),
      .bucket (bucket),
      .res    (res[ch]),
      .done   (lane_done[ch])
    );
  end

  cefq_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .load      (merge_load),
    .res       (res),
    .thr       (mag_threshold),
    .row_end   (row_end),
    .frame_end (frame_end),
    .free      (merge_free),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser)
  );

endmodule

@@ tb/tb.sv @@
// Self-checking testbench for the cartoon edge and quantise filter unit.
`timescale 1ns / 1ps

module tb;
  import cefq_pkg::*;

  typedef struct {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       row_end;
    logic       frame_end;
  } cartoon_px_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [PX_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b1;
  logic [PX_W-1:0]   m_tdata;
  logic              m_tlast;
  logic              m_tuser;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [1:0]        cfg_index = '0;
  logic [CNT_W-1:0]  cfg_data = '0;

  // Predictor state: registers, line store, window and raster counters.
  int unsigned       width_reg = 640;
  int unsigned       height_reg = 480;
  int unsigned       levels_reg = 10;
  int unsigned       thresh_reg = 15;
  logic [PX_W-1:0]   line_mem [4][MAX_WIDTH];
  logic [7:0]        win_mem [3][5][5];
  int unsigned       col_count = 0;
  int unsigned       row_count = 0;

  cartoon_px_t       expected_px [$];
  int                error_count = 0;
  int                pixels_sent = 0;
  int                burst_left = 0;
  int                gap_left = 0;
  int                stall_mode = 0;
  int unsigned       cycle_count = 0;

  cartoon_edge_quantize_filter_unit u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("cartoon_edge_quantize_filter_unit verification failed");
    $finish;
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    error_count++;
  endtask

  // Work out the cartoon pixel, if any, that one accepted input pixel produces.
  task automatic model_pixel(input logic [PX_W-1:0] px);
    int unsigned w, h, col, row, slot, bucket, blur, hs1, hs3, sq, root, b;
    int unsigned hor [5];
    int unsigned quant [3];
    int          s, gx, gy;
    bit          black;
    cartoon_px_t res;
    w = (width_reg < 5) ? 5 : (width_reg > MAX_WIDTH ? MAX_WIDTH : width_reg);
    h = (height_reg < 5) ? 5 : (height_reg > MAX_HEIGHT ? MAX_HEIGHT : height_reg);
    if (col_count >= w) begin
      col_count = 0;
      row_count++;
    end
    if (row_count >= h) row_count = 0;
    col = col_count;
    row = row_count;
    slot = row & 3;
    // Shift the window and bring in the new column from the line store.
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 5; r++)
        for (int c = 0; c < 4; c++) win_mem[ch][r][c] = win_mem[ch][r][c+1];
      for (int r = 0; r < 4; r++)
        win_mem[ch][r][4] = line_mem[(slot + r) & 3][col][8*ch +: 8];
      win_mem[ch][4][4] = px[8*ch +: 8];
    end
    line_mem[slot][col] = px;

    if (row >= 4 && col >= 4) begin
      bucket = 255 / (levels_reg == 0 ? 1 : levels_reg);
      black = 1'b0;
      for (int ch = 0; ch < 3; ch++) begin
        for (int r = 0; r < 5; r++)
          hor[r] = (win_mem[ch][r][0] + 2*win_mem[ch][r][1] + 4*win_mem[ch][r][2]
                    + 2*win_mem[ch][r][3] + win_mem[ch][r][4]) / 10;
        blur = (hor[0] + 2*hor[1] + 4*hor[2] + 2*hor[3] + hor[4]) / 10;
        quant[ch] = (blur / bucket) * bucket;
        s = (int'(win_mem[ch][1][3]) - int'(win_mem[ch][1][1]))
          + 2 * (int'(win_mem[ch][2][3]) - int'(win_mem[ch][2][1]))
          + (int'(win_mem[ch][3][3]) - int'(win_mem[ch][3][1]));
        gx = s / 4;
        hs1 = (win_mem[ch][1][1] + 2*win_mem[ch][1][2] + win_mem[ch][1][3]) / 4;
        hs3 = (win_mem[ch][3][1] + 2*win_mem[ch][3][2] + win_mem[ch][3][3]) / 4;
        gy = int'(hs1) - int'(hs3);
        sq = gx*gx + gy*gy;
        root = 0;
        for (b = 512; b != 0; b = b >> 1)
          if ((root + b) * (root + b) <= sq) root += b;
        if (root > thresh_reg) black = 1'b1;
      end
      res.blue = black ? 8'd0 : quant[0][7:0];
      res.green = black ? 8'd0 : quant[1][7:0];
      res.red = black ? 8'd0 : quant[2][7:0];
      res.row_end = (col == w - 1);
      res.frame_end = (col == w - 1) && (row == h - 1);
      expected_px.push_back(res);
    end
    col_count = col + 1;
  endtask

  // Send one pixel request, in bursts separated by random gaps.
  task automatic send_pixel(input logic [PX_W-1:0] px);
    if (gap_left > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap_left) @(posedge clk);
      gap_left = 0;
    end
    s_tvalid <= 1'b1;
    s_tdata <= px;
    do @(posedge clk); while (!(s_tvalid && s_tready));
    model_pixel(px);
    pixels_sent++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(40, 120) : $urandom_range(0, 8);
      gap_left = $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 6);
    end
  endtask

  // Stop sending and wait until every expected pixel has arrived.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_px.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[CNT_W-1:0];
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    case (idx)
      REG_WIDTH:  width_reg = value & 11'h7FF;
      REG_HEIGHT: height_reg = value & 11'h7FF;
      REG_LEVELS: levels_reg = value & 8'hFF;
      default:    thresh_reg = value & 9'h1FF;
    endcase
  endtask

  task automatic configure(input int unsigned w, input int unsigned h,
                           input int unsigned lv, input int unsigned th);
    write_reg(REG_WIDTH, w);
    write_reg(REG_HEIGHT, h);
    write_reg(REG_LEVELS, lv);
    write_reg(REG_THRESHOLD, th);
  endtask

  // Send a number of pixels: noise, smooth areas with small ripple, or repeated hard steps.
  task automatic send_pixels(input int count, input int style);
    logic [PX_W-1:0] base, px;
    base = $urandom();
    for (int i = 0; i < count; i++) begin
      case (style)
        0: px = $urandom();
        1: for (int ch = 0; ch < 3; ch++)
             px[8*ch +: 8] = base[8*ch +: 8] ^ 8'($urandom_range(0, 3));
        default: px = ((i % 7) < 3) ? base : ~base;
      endcase
      send_pixel(px);
    end
  endtask

  // A first frame wider than any later one, so that every line store entry
  // read later has already been written.
  task automatic test_widest_frame;
    configure(16, 5, 255, 361);
    send_pixels(16 * 5, 0);
    drain();
  endtask

  // Clamped small size, zero levels, zero and largest thresholds.
  task automatic test_smallest_frame;
    configure(3, 2, 0, 0);
    send_pixels(25, 1);
    drain();
    write_reg(REG_LEVELS, 1);
    write_reg(REG_THRESHOLD, 511);
    send_pixels(25, 0);
    drain();
    send_pixels(25, 2);
    drain();
  endtask

  // Size changes while a frame is part way through.
  task automatic test_size_change;
    configure(8, 6, 7, 40);
    send_pixels(22, 1);
    drain();
    write_reg(REG_WIDTH, 5);
    send_pixels(21, 1);
    drain();
    write_reg(REG_HEIGHT, 2047);
    write_reg(REG_WIDTH, 9);
    send_pixels(60, 2);
    drain();
    write_reg(REG_HEIGHT, 5);
    send_pixels(40, 1);
    drain();
  endtask

  // Random frames with random settings.
  task automatic test_random_frames;
    int w, h, lv, th;
    while (pixels_sent < 860) begin
      w = $urandom_range(5, 12);
      h = $urandom_range(5, 8);
      case ($urandom_range(0, 3))
        0: lv = $urandom_range(0, 1);
        1: lv = 255;
        default: lv = $urandom_range(2, 254);
      endcase
      th = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511) : $urandom_range(5, 80);
      configure(w, h, lv, th);
      send_pixels(w * h, $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 2));
      drain();
    end
  endtask

  // Receiver stall patterns: always ready, random stalls or a repeating pattern, picked anew at regular intervals.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 2);
    case (stall_mode)
      0: m_tready <= 1'b1;
      1: m_tready <= ($urandom_range(0, 3) != 0);
      default: m_tready <= ((cycle_count % 7) < 4);
    endcase
  end

  // Compare each returned pixel with the oldest expected one.
  always @(posedge clk) begin
    cartoon_px_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (expected_px.size() == 0) begin
        $display("MISMATCH unexpected pixel at %0t", $realtime);
        error_count++;
      end else begin
        want = expected_px.pop_front();
        if (m_tdata[7:0] !== want.blue) report_mismatch("blue", m_tdata[7:0], want.blue);
        if (m_tdata[15:8] !== want.green) report_mismatch("green", m_tdata[15:8], want.green);
        if (m_tdata[23:16] !== want.red) report_mismatch("red", m_tdata[23:16], want.red);
        if (m_tlast !== want.row_end) report_mismatch("row_end", m_tlast, want.row_end);
        if (m_tuser !== want.frame_end) report_mismatch("frame_end", m_tuser, want.frame_end);
      end
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_widest_frame();
    test_smallest_frame();
    test_size_change();
    test_random_frames();
    drain();
    if (error_count == 0 && expected_px.size() == 0) begin
      $display("cartoon_edge_quantize_filter_unit verification clean");
    end else begin
      $display("cartoon_edge_quantize_filter_unit verification failed");
    end
    $finish;
  end

endmodule
